/* hw/rtl/gqi_pkg.sv */
package gqi_pkg;

    // fixed-point constants
    localparam int unsigned Q_ONE          = 16384;
    localparam int unsigned INC_DIV        = 8000000;
    localparam int unsigned INC_HALF       = INC_DIV / 2;
    localparam int unsigned MAX_STEP_RESET = 50000;

    // shared serial unit widths
    localparam int unsigned MC_W   = 32;
    localparam int unsigned MR_W   = 25;
    localparam int unsigned PR_W   = MC_W + MR_W;
    localparam int unsigned DIV_NW = 48;
    localparam int unsigned DIV_DW = 26;
    localparam int unsigned SQ_W   = 52;
    localparam int unsigned RT_W   = SQ_W / 2;
    localparam int unsigned V_W    = 26;

    // component indexes
    localparam logic [1:0] C_X = 2'd0;
    localparam logic [1:0] C_Y = 2'd1;
    localparam logic [1:0] C_Z = 2'd2;
    localparam logic [1:0] C_W = 2'd3;

    // configuration register index
    localparam logic REG_MAX_STEP = 1'b0;

    // one term of the quaternion product
    typedef struct packed {
        logic [1:0] qsel;
        logic [1:0] rsel;
        logic       neg;
    } t_term;

    // p = q * (r, 0), three terms per component
    function automatic t_term term_of(input logic [1:0] comp, input logic [1:0] idx);
        t_term t;
        t = '{qsel: C_W, rsel: C_X, neg: 1'b0};
        unique case ({comp, idx})
            {C_X, 2'd0}: t = '{qsel: C_W, rsel: C_X, neg: 1'b0};
            {C_X, 2'd1}: t = '{qsel: C_Y, rsel: C_Z, neg: 1'b0};
            {C_X, 2'd2}: t = '{qsel: C_Z, rsel: C_Y, neg: 1'b1};
            {C_Y, 2'd0}: t = '{qsel: C_W, rsel: C_Y, neg: 1'b0};
            {C_Y, 2'd1}: t = '{qsel: C_Z, rsel: C_X, neg: 1'b0};
            {C_Y, 2'd2}: t = '{qsel: C_X, rsel: C_Z, neg: 1'b1};
            {C_Z, 2'd0}: t = '{qsel: C_W, rsel: C_Z, neg: 1'b0};
            {C_Z, 2'd1}: t = '{qsel: C_X, rsel: C_Y, neg: 1'b0};
            {C_Z, 2'd2}: t = '{qsel: C_Y, rsel: C_X, neg: 1'b1};
            {C_W, 2'd0}: t = '{qsel: C_X, rsel: C_X, neg: 1'b1};
            {C_W, 2'd1}: t = '{qsel: C_Y, rsel: C_Y, neg: 1'b1};
            {C_W, 2'd2}: t = '{qsel: C_Z, rsel: C_Z, neg: 1'b1};
            default:     t = '{qsel: C_W, rsel: C_X, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/gqi_smul.sv */
module gqi_smul
    import gqi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MC_W-1:0] i_mcand,
    input  logic [MR_W-1:0] i_mplier,
    output logic            o_done,
    output logic [PR_W-1:0] o_prod
);

    logic            r_busy;
    logic            r_done;
    logic [PR_W-1:0] r_mcand;
    logic [MR_W-1:0] r_mplier;
    logic [PR_W-1:0] r_acc;

    // control: run until no multiplier bits remain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_mplier == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // shift-add datapath, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PR_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy && r_mplier != '0) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hw/rtl/gqi_sdiv.sv */
module gqi_sdiv
    import gqi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(DIV_NW + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    // bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // restoring division, quotient bits shift in behind the numerator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_cnt != '0) begin
            if (w_fit) begin
                r_rem <= DIV_DW'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[DIV_DW-1:0];
            end
            r_num <= {r_num[DIV_NW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* hw/rtl/gqi_isqrt.sv */
module gqi_isqrt
    import gqi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_val,
    output logic            o_done,
    output logic [RT_W-1:0] o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_x;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] w_trial;

    assign w_trial = r_r + r_bit;

    // control: one result bit per cycle until the probe bit runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // digit-by-digit square root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_val;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy && r_bit != '0) begin
            if (r_x >= w_trial) begin
                r_x <= r_x - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[RT_W-1:0];

endmodule

/* hw/rtl/gyro_quaternion_integrator_top.sv */
// the shared bit-serial multiplier (one multiplier bit per cycle) and restoring divider
//   set how long a transaction takes; transactions are taken one at a time
// input is accepted only in the idle state; a finished result waits in the
//   output register while the next input is accepted
// reset: synchronous active-low i_rst_n; orientation returns to identity and max_step_us to 50000
module gyro_quaternion_integrator_top
    import gqi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // rate_x, rate_y, rate_z, delta_t
    input  logic        s_axis_tuser,   // restart
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);

    typedef enum logic [3:0] {
        S_IDLE, S_PMUL, S_PWAIT, S_DMUL, S_DWAIT, S_IDIV, S_IWAIT,
        S_SQMUL, S_SQWAIT, S_SQRT, S_RTWAIT, S_NDIV, S_NWAIT, S_OUT
    } t_state;

    t_state             r_state;
    logic [15:0]        r_max_step;
    logic signed [15:0] r_q [4];
    logic signed [15:0] r_rate [3];
    logic [15:0]        r_dt;
    logic [1:0]         r_comp;
    logic [1:0]         r_term;
    logic signed [31:0] r_p;
    logic signed [V_W-1:0] r_v [4];
    logic [SQ_W-1:0]    r_sum;
    logic [RT_W-1:0]    r_n;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic               w_in_acc;
    logic               w_cfg_wr;
    t_term              w_term;
    logic signed [15:0] w_qv;
    logic signed [15:0] w_rv;
    logic [15:0]        w_qmag;
    logic [15:0]        w_rmag;
    logic [31:0]        w_pmag;
    logic signed [V_W-1:0] w_vcur;
    logic [V_W-2:0]     w_vmag;
    logic signed [V_W-1:0] w_vbase;
    logic signed [V_W-1:0] w_inc;
    logic [15:0]        w_nmag;

    logic               w_mul_start, w_mul_done;
    logic [MC_W-1:0]    w_mcand;
    logic [MR_W-1:0]    w_mplier;
    logic [PR_W-1:0]    w_prod;
    logic               w_div_start, w_div_done;
    logic [DIV_NW-1:0]  w_num;
    logic [DIV_DW-1:0]  w_den;
    logic [DIV_NW-1:0]  w_quot;
    logic               w_sq_start, w_sq_done;
    logic [RT_W-1:0]    w_root;

    // handshakes
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign pready        = 1'b1;
    assign prdata        = {16'd0, r_max_step};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // operand selection
    assign w_term  = term_of(r_comp, r_term);
    assign w_qv    = r_q[w_term.qsel];
    assign w_rv    = r_rate[w_term.rsel[1:0] == 2'd3 ? 2'd0 : w_term.rsel];
    assign w_qmag  = w_qv[15] ? 16'(-w_qv) : 16'(w_qv);
    assign w_rmag  = w_rv[15] ? 16'(-w_rv) : 16'(w_rv);
    assign w_pmag  = r_p[31] ? 32'(-r_p) : 32'(r_p);
    assign w_vcur  = r_v[r_comp];
    assign w_vmag  = w_vcur[V_W-1] ? (V_W-1)'(-w_vcur) : (V_W-1)'(w_vcur);
    assign w_vbase = V_W'(r_q[r_comp]) <<< 8;
    assign w_inc   = V_W'({1'b0, w_quot[V_W-2:0]});
    assign w_nmag  = (w_quot > DIV_NW'(Q_ONE)) ? 16'(Q_ONE) : w_quot[15:0];

    // unit operands
    always_comb begin
        w_mcand  = MC_W'(w_qmag);
        w_mplier = MR_W'(w_rmag);
        unique case (r_state)
            S_DMUL: begin
                w_mcand  = w_pmag;
                w_mplier = MR_W'(r_dt);
            end
            S_SQMUL: begin
                w_mcand  = MC_W'(w_vmag);
                w_mplier = MR_W'(w_vmag);
            end
            default: begin
                w_mcand  = MC_W'(w_qmag);
                w_mplier = MR_W'(w_rmag);
            end
        endcase
    end

    always_comb begin
        if (r_state == S_NDIV) begin
            w_num = DIV_NW'({w_vmag, 14'd0}) + DIV_NW'(r_n >> 1);
            w_den = DIV_DW'(r_n);
        end else begin
            w_num = DIV_NW'(w_prod) + DIV_NW'(INC_HALF);
            w_den = DIV_DW'(INC_DIV);
        end
    end

    assign w_mul_start = (r_state == S_PMUL) || (r_state == S_DMUL) || (r_state == S_SQMUL);
    assign w_div_start = (r_state == S_IDIV) || (r_state == S_NDIV);
    assign w_sq_start  = (r_state == S_SQRT);

    gqi_smul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    gqi_sdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    gqi_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_sum),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= 16'(MAX_STEP_RESET);
        end else if (w_cfg_wr && paddr[2] == REG_MAX_STEP) begin
            r_max_step <= pwdata[15:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_q[C_X]    <= '0;
            r_q[C_Y]    <= '0;
            r_q[C_Z]    <= '0;
            r_q[C_W]    <= 16'(Q_ONE);
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_rate[0] <= s_axis_tdata[15:0];
                        r_rate[1] <= s_axis_tdata[31:16];
                        r_rate[2] <= s_axis_tdata[47:32];
                        r_dt      <= (s_axis_tdata[63:48] > r_max_step) ? r_max_step
                                                                         : s_axis_tdata[63:48];
                        if (s_axis_tuser) begin
                            r_q[C_X] <= '0;
                            r_q[C_Y] <= '0;
                            r_q[C_Z] <= '0;
                            r_q[C_W] <= 16'(Q_ONE);
                        end
                        r_comp  <= C_X;
                        r_term  <= 2'd0;
                        r_p     <= '0;
                        r_sum   <= '0;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (w_mul_done) begin
                        if (w_term.neg ^ w_qv[15] ^ w_rv[15]) begin
                            r_p <= r_p - 32'(w_prod[29:0]);
                        end else begin
                            r_p <= r_p + 32'(w_prod[29:0]);
                        end
                        if (r_term == 2'd2) begin
                            r_term  <= 2'd0;
                            r_state <= S_DMUL;
                        end else begin
                            r_term  <= r_term + 2'd1;
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_DMUL: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_mul_done) begin
                        r_state <= S_IDIV;
                    end
                end
                S_IDIV: r_state <= S_IWAIT;
                S_IWAIT: begin
                    if (w_div_done) begin
                        r_v[r_comp] <= r_p[31] ? w_vbase - w_inc : w_vbase + w_inc;
                        r_p         <= '0;
                        r_comp      <= r_comp + 2'd1;
                        r_state     <= (r_comp == C_W) ? S_SQMUL : S_PMUL;
                    end
                end
                S_SQMUL: r_state <= S_SQWAIT;
                S_SQWAIT: begin
                    if (w_mul_done) begin
                        r_sum   <= r_sum + SQ_W'(w_prod[2*(V_W-1)-1:0]);
                        r_comp  <= r_comp + 2'd1;
                        r_state <= (r_comp == C_W) ? S_SQRT : S_SQMUL;
                    end
                end
                S_SQRT: r_state <= S_RTWAIT;
                S_RTWAIT: begin
                    if (w_sq_done) begin
                        r_n <= w_root;
                        if (w_root == '0) begin
                            r_q[C_X] <= '0;
                            r_q[C_Y] <= '0;
                            r_q[C_Z] <= '0;
                            r_q[C_W] <= 16'(Q_ONE);
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_NDIV: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (w_div_done) begin
                        r_q[r_comp] <= w_vcur[V_W-1] ? 16'(-w_nmag) : w_nmag;
                        r_comp      <= r_comp + 2'd1;
                        r_state     <= (r_comp == C_W) ? S_OUT : S_NDIV;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_data  <= {r_q[C_W], r_q[C_Z], r_q[C_Y], r_q[C_X]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_PMUL)
        else $error("accepted transaction did not start the product");

    a_step_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PMUL) |-> r_dt <= r_max_step)
        else $error("integration step above the configured maximum");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output state");

    a_quat_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_q[C_W] <= 16'sd16384 && r_q[C_W] >= -16'sd16384
                                 && r_q[C_X] <= 16'sd16384 && r_q[C_X] >= -16'sd16384))
        else $error("stored quaternion component out of range");
`endif

endmodule

/* tb/sv/gyro_quaternion_integrator_top_tb.sv */
`timescale 1ns / 100ps

module gyro_quaternion_integrator_top_tb;
    import gqi_pkg::*;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        delta_t;
        logic               restart;
    } t_gyro_sample;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_attitude;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // rate_x, rate_y, rate_z, delta_t
    logic        s_axis_tuser;   // restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // quat_x, quat_y, quat_z, quat_w

    gyro_quaternion_integrator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_gyro_sample sample_queue[$];
    t_attitude    attitude_queue[$];
    longint       att_model[4];
    longint       max_step_model;
    int           error_count;
    bit           calm_out;
    bit           calm_in;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // round half away from zero, den > 0
    function automatic longint div_away(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint root_floor(input longint val);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > val) b = b >>> 2;
        while (b != 0) begin
            if (val >= r + b) begin
                val = val - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // one euler step of the orientation and its renormalization
    function automatic t_attitude integrate_sample(input t_gyro_sample s);
        longint rx, ry, rz, dt, x, y, z, w, nrm, sum, r;
        longint p[4];
        longint v[4];
        t_attitude res;
        rx = s.rate_x;
        ry = s.rate_y;
        rz = s.rate_z;
        dt = s.delta_t;
        if (s.restart) att_model = '{0, 0, 0, Q_ONE};
        if (dt > max_step_model) dt = max_step_model;
        x = att_model[0];
        y = att_model[1];
        z = att_model[2];
        w = att_model[3];
        p[0] = w * rx + y * rz - z * ry;
        p[1] = w * ry + z * rx - x * rz;
        p[2] = w * rz + x * ry - y * rx;
        p[3] = -x * rx - y * ry - z * rz;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            v[i] = att_model[i] * 256 + div_away(p[i] * dt, INC_DIV);
            sum += v[i] * v[i];
        end
        nrm = root_floor(sum);
        if (nrm == 0) begin
            att_model = '{0, 0, 0, Q_ONE};
        end else begin
            for (int i = 0; i < 4; i++) begin
                r = div_away(v[i] * longint'(Q_ONE), nrm);
                if (r > longint'(Q_ONE)) r = longint'(Q_ONE);
                if (r < -longint'(Q_ONE)) r = -longint'(Q_ONE);
                att_model[i] = r;
            end
        end
        res.quat_x = att_model[0][15:0];
        res.quat_y = att_model[1][15:0];
        res.quat_z = att_model[2][15:0];
        res.quat_w = att_model[3][15:0];
        return res;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (sample_queue.size() > 0 && (calm_in || $urandom_range(99) >= 12)) begin
                t_gyro_sample s;
                s = sample_queue.pop_front();
                attitude_queue.push_back(integrate_sample(s));
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {s.delta_t, s.rate_z, s.rate_y, s.rate_x};
                s_axis_tuser <= s.restart;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output stall pattern
    always @(posedge i_clk) begin
        m_axis_tready <= calm_out || ($urandom_range(99) >= 12);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_attitude got;
            t_attitude exp_att;
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[63:48]};
            if (attitude_queue.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_att = attitude_queue.pop_front();
                if (got.quat_x !== exp_att.quat_x) begin
                    $error("quat_x expected %0d got %0d", exp_att.quat_x, got.quat_x);
                    error_count++;
                end
                if (got.quat_y !== exp_att.quat_y) begin
                    $error("quat_y expected %0d got %0d", exp_att.quat_y, got.quat_y);
                    error_count++;
                end
                if (got.quat_z !== exp_att.quat_z) begin
                    $error("quat_z expected %0d got %0d", exp_att.quat_z, got.quat_z);
                    error_count++;
                end
                if (got.quat_w !== exp_att.quat_w) begin
                    $error("quat_w expected %0d got %0d", exp_att.quat_w, got.quat_w);
                    error_count++;
                end
            end
        end
    end

    task automatic write_max_step(input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_STEP, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_step_model = val;
    endtask

    task automatic wait_drained();
        while (sample_queue.size() > 0 || attitude_queue.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_sample(input int rx, input int ry, input int rz, input int dt,
                              input bit rs);
        t_gyro_sample s;
        s.rate_x = 16'(rx);
        s.rate_y = 16'(ry);
        s.rate_z = 16'(rz);
        s.delta_t = 16'(dt);
        s.restart = rs;
        sample_queue.push_back(s);
    endtask

    // mostly moderate rates and steps, some full-range noise
    task automatic add_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0)
                add_sample($urandom, $urandom, $urandom, $urandom, $urandom_range(1) == 1);
            else
                add_sample($signed($urandom_range(4000)) - 2000,
                           $signed($urandom_range(4000)) - 2000,
                           $signed($urandom_range(4000)) - 2000,
                           $urandom_range(20000), $urandom_range(19) == 0);
        end
    endtask

    initial begin
        error_count = 0;
        max_step_model = MAX_STEP_RESET;
        att_model = '{0, 0, 0, Q_ONE};
        calm_in = 1'b0;
        calm_out = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero step, clamp, restart
        add_sample(0, 0, 0, 0, 0);
        add_sample(32767, 32767, 32767, 65535, 0);
        add_sample(-32768, -32768, -32768, 65535, 0);
        add_sample(1000, 0, 0, 1000, 0);
        add_sample(0, -1000, 0, 1000, 0);
        add_sample(0, 0, 2000, 50000, 0);
        add_sample(0, 0, 0, 0, 1);
        add_sample(32767, -32768, 12345, 50001, 1);
        add_sample(-1, 1, -1, 1, 0);
        add_sample(500, 500, -500, 0, 0);
        wait_drained();

        // zero maximum: everything clamps to no rotation
        write_max_step(16'd0);
        add_sample(32767, 32767, -32768, 65535, 0);
        add_sample(1234, -4321, 77, 100, 1);
        wait_drained();

        write_max_step(16'hFFFF);
        add_sample(-32768, 32767, -32768, 65535, 1);
        add_random(250);
        wait_drained();

        write_max_step(16'd1);
        add_random(100);
        wait_drained();

        // no idling stretch
        write_max_step(16'd20000);
        calm_in = 1'b1;
        calm_out = 1'b1;
        add_random(150);
        wait_drained();
        calm_in = 1'b0;
        calm_out = 1'b0;

        write_max_step(16'($urandom));
        add_random(430);
        wait_drained();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/gqi_pkg.sv
hw/rtl/gqi_smul.sv
hw/rtl/gqi_sdiv.sv
hw/rtl/gqi_isqrt.sv
hw/rtl/gyro_quaternion_integrator_top.sv
tb/sv/gyro_quaternion_integrator_top_tb.sv
